[hw/rtl/tpfe_pkg.sv]
// Shared types and constants for the touch point filter and event detector.
package tpfe_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int THR_W      = 16;
   localparam int MOVE_W     = 12;
   localparam int SPAN_W     = 12;
   localparam int COEF_W     = 16;
   localparam int POS_W      = 22;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam int SCALE_W          = SAMPLE_W + SPAN_W;
   localparam int DIV100_SHIFT     = 35;
   localparam int DIV100_RECIP_W   = 29;
   localparam logic [DIV100_RECIP_W-1:0] DIV100_RECIP = 29'd343597384;
   localparam int DIV100_W         = SCALE_W + DIV100_RECIP_W;
   localparam int RAW_W            = 22;
   localparam int CAL_PROD_W       = RAW_W + 1 + COEF_W;
   localparam int CAL_NUM_W        = CAL_PROD_W + 1;
   localparam int FRAC_W           = 12;
   localparam int CAL_Q_W          = CAL_NUM_W - FRAC_W;

   typedef logic signed [POS_W-1:0] pos_type;

   localparam pos_type POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam pos_type POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef struct packed {
      pos_type x;
      pos_type y;
   } hist_entry_type;

   typedef struct packed {
      logic [THR_W-1:0]         press_threshold;
      logic [MOVE_W-1:0]        move_threshold;
      logic [SPAN_W-1:0]        x_span;
      logic [SPAN_W-1:0]        y_span;
      logic signed [COEF_W-1:0] x_slope;
      logic signed [COEF_W-1:0] x_offset;
      logic signed [COEF_W-1:0] y_slope;
      logic signed [COEF_W-1:0] y_offset;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      press_threshold: 16'd50,
      move_threshold:  12'd5,
      x_span:          12'd800,
      y_span:          12'd480,
      x_slope:         16'sd4096,
      x_offset:        16'sd0,
      y_slope:         16'sd4096,
      y_offset:        16'sd0
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESS_THRESHOLD = 4'd0,
      CSR_MOVE_THRESHOLD  = 4'd1,
      CSR_X_SPAN          = 4'd2,
      CSR_Y_SPAN          = 4'd3,
      CSR_X_SLOPE         = 4'd4,
      CSR_X_OFFSET        = 4'd5,
      CSR_Y_SLOPE         = 4'd6,
      CSR_Y_OFFSET        = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2,
      EV_MOVE    = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV,
      ST_MUL,
      ST_SAT,
      ST_ACC,
      ST_AVG,
      ST_OUT
   } state_type;

endpackage

[hw/rtl/tpfe_if.sv]
// Channel interfaces for sample requests, event responses and register writes.
interface tpfe_req_if import tpfe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_a;
   logic [SAMPLE_W-1:0] sample_b;
   logic [SAMPLE_W-1:0] sample_c;
   logic [SAMPLE_W-1:0] sample_d;

   modport source (output valid, sample_a, sample_b, sample_c, sample_d, input ready);
   modport sink (input valid, sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

interface tpfe_rsp_if import tpfe_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] touch_event;
   logic       touched;
   pos_type    pos_x;
   pos_type    pos_y;

   modport source (output valid, touch_event, touched, pos_x, pos_y, input ready);
   modport sink (input valid, touch_event, touched, pos_x, pos_y, output ready);
endinterface

interface tpfe_csr_if import tpfe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/tpfe_hist_ram.sv]
// History ring memory with per-entry valid bits; unwritten entries read as zero.
module tpfe_hist_ram import tpfe_pkg::*; #(
   parameter int DEPTH  = 4,
   parameter int ADDR_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output hist_entry_type    rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  hist_entry_type    wr_data
);

   hist_entry_type    mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   hist_entry_type    rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/touch_point_filter_event.sv]
// Touch point filter and event detector top level.
// A touched sample set passes the sequencer states SCALE, DIV, MUL, SAT, ACC, AVG and
// OUT before it is in the response register, an untouched one SCALE and OUT only; one
// transaction is held at a time, and OUT stalls while a held response is not taken.
// Synchronous active-high reset restores the register defaults, zeroes the history
// ring through its valid bits and clears the running sums and last point.
module touch_point_filter_event import tpfe_pkg::*; #(
   parameter int AVG_DEPTH = 4
) (
   input logic         clock,
   input logic         reset,
   tpfe_req_if.sink    req_ch,
   tpfe_rsp_if.source  rsp_ch,
   tpfe_csr_if.sink    csr_ch
);

   localparam int ADDR_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W     = POS_W + $clog2(AVG_DEPTH);
   localparam int AVG_SHIFT = SUM_W + $clog2(AVG_DEPTH) + 1;
   localparam int RECIP_W   = AVG_SHIFT + 1;
   localparam int AVGP_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;

   logic                     req_ready;
   logic                     req_accept;
   logic                     rd_en;
   logic                     wr_en;
   logic                     rsp_load;
   hist_entry_type           old_entry;

   logic [ADDR_W-1:0]        slot_ff, slot_in;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                     last_pressed_ff, last_pressed_in;
   pos_type                  last_x_ff, last_x_in, last_y_ff, last_y_in;

   logic [SAMPLE_W-1:0]      samp_a_ff, samp_a_in, samp_b_ff, samp_b_in;
   logic                     pressed_ff, pressed_in;
   logic [SCALE_W-1:0]       prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [DIV100_W-1:0]      div_x_ff, div_x_in, div_y_ff, div_y_in;
   logic signed [CAL_PROD_W-1:0] mul_x_ff, mul_x_in, mul_y_ff, mul_y_in;
   pos_type                  cal_x_ff, cal_x_in, cal_y_ff, cal_y_in;
   logic [AVGP_W-1:0]        avgp_x_ff, avgp_x_in, avgp_y_ff, avgp_y_in;
   logic                     neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   event_type                rsp_event_ff, rsp_event_in;
   logic                     rsp_touched_ff, rsp_touched_in;
   pos_type                  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic                     any_low;
   logic [RAW_W-1:0]         raw_x, raw_y;
   logic [SUM_W-1:0]         mag_x, mag_y;
   logic [POS_W-1:0]         avg_mag_x, avg_mag_y;
   pos_type                  px, py;
   logic signed [POS_W:0]    dx, dy;
   logic [POS_W:0]           adx, ady;
   event_type                ev;

   function automatic pos_type cal_sat(input logic signed [CAL_PROD_W-1:0] prod,
                                       input logic signed [COEF_W-1:0] offset);
      logic signed [CAL_NUM_W-1:0] num;
      logic signed [CAL_NUM_W-1:0] adj;
      logic signed [CAL_Q_W-1:0]   q;
      num = {prod[CAL_PROD_W-1], prod}
            + {{(CAL_NUM_W-COEF_W-FRAC_W){offset[COEF_W-1]}}, offset, {FRAC_W{1'b0}}};
      adj = num + {{(CAL_NUM_W-FRAC_W){1'b0}}, {FRAC_W{num[CAL_NUM_W-1]}}};
      q   = adj[CAL_NUM_W-1:FRAC_W];
      if (q[CAL_Q_W-1:POS_W-1] == {(CAL_Q_W-POS_W+1){q[CAL_Q_W-1]}}) begin
         return q[POS_W-1:0];
      end else begin
         return q[CAL_Q_W-1] ? POS_MIN : POS_MAX;
      end
   endfunction

   tpfe_hist_ram #(
      .DEPTH  (AVG_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_hist_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (slot_ff),
      .rd_data (old_entry),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data ('{x: cal_x_ff, y: cal_y_ff})
   );

   // Configuration port.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_PRESS_THRESHOLD: cfg_in.press_threshold = csr_ch.data;
            CSR_MOVE_THRESHOLD:  cfg_in.move_threshold  = csr_ch.data[MOVE_W-1:0];
            CSR_X_SPAN:          cfg_in.x_span          = csr_ch.data[SPAN_W-1:0];
            CSR_Y_SPAN:          cfg_in.y_span          = csr_ch.data[SPAN_W-1:0];
            CSR_X_SLOPE:         cfg_in.x_slope         = csr_ch.data;
            CSR_X_OFFSET:        cfg_in.x_offset        = csr_ch.data;
            CSR_Y_SLOPE:         cfg_in.y_slope         = csr_ch.data;
            CSR_Y_OFFSET:        cfg_in.y_offset        = csr_ch.data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_SCALE;
         ST_SCALE: state_in = pressed_ff ? ST_DIV : ST_OUT;
         ST_DIV:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_SAT;
         ST_SAT:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_AVG;
         ST_AVG:   state_in = ST_OUT;
         ST_OUT:   if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_en     = req_ch.valid;
         end
         ST_ACC:  wr_en = 1'b1;
         ST_OUT:  rsp_load = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign req_ch.ready = req_ready;
   assign req_accept   = req_ch.valid && req_ready;

   assign any_low = (req_ch.sample_a < cfg_ff.press_threshold)
                 || (req_ch.sample_b < cfg_ff.press_threshold)
                 || (req_ch.sample_c < cfg_ff.press_threshold)
                 || (req_ch.sample_d < cfg_ff.press_threshold);

   assign raw_x = div_x_ff[DIV100_SHIFT +: RAW_W];
   assign raw_y = div_y_ff[DIV100_SHIFT +: RAW_W];

   assign mag_x = sum_x_ff[SUM_W-1] ? (~sum_x_ff + 1'b1) : sum_x_ff;
   assign mag_y = sum_y_ff[SUM_W-1] ? (~sum_y_ff + 1'b1) : sum_y_ff;

   assign avg_mag_x = avgp_x_ff[AVG_SHIFT +: POS_W];
   assign avg_mag_y = avgp_y_ff[AVG_SHIFT +: POS_W];

   assign px = !pressed_ff ? '0 : (neg_x_ff ? pos_type'(~avg_mag_x + 1'b1) : avg_mag_x);
   assign py = !pressed_ff ? '0 : (neg_y_ff ? pos_type'(~avg_mag_y + 1'b1) : avg_mag_y);

   assign dx  = {px[POS_W-1], px} - {last_x_ff[POS_W-1], last_x_ff};
   assign dy  = {py[POS_W-1], py} - {last_y_ff[POS_W-1], last_y_ff};
   assign adx = dx[POS_W] ? (~dx + 1'b1) : dx;
   assign ady = dy[POS_W] ? (~dy + 1'b1) : dy;

   always_comb begin
      priority if (pressed_ff && !last_pressed_ff) begin
         ev = EV_PRESS;
      end else if (!pressed_ff && last_pressed_ff) begin
         ev = EV_RELEASE;
      end else if (pressed_ff && ((adx > (POS_W+1)'(cfg_ff.move_threshold))
                               || (ady > (POS_W+1)'(cfg_ff.move_threshold)))) begin
         ev = EV_MOVE;
      end else begin
         ev = EV_NONE;
      end
   end

   // Datapath next values.
   always_comb begin
      samp_a_in       = samp_a_ff;
      samp_b_in       = samp_b_ff;
      pressed_in      = pressed_ff;
      prod_x_in       = prod_x_ff;
      prod_y_in       = prod_y_ff;
      div_x_in        = div_x_ff;
      div_y_in        = div_y_ff;
      mul_x_in        = mul_x_ff;
      mul_y_in        = mul_y_ff;
      cal_x_in        = cal_x_ff;
      cal_y_in        = cal_y_ff;
      avgp_x_in       = avgp_x_ff;
      avgp_y_in       = avgp_y_ff;
      neg_x_in        = neg_x_ff;
      neg_y_in        = neg_y_ff;
      slot_in         = slot_ff;
      sum_x_in        = sum_x_ff;
      sum_y_in        = sum_y_ff;
      last_pressed_in = last_pressed_ff;
      last_x_in       = last_x_ff;
      last_y_in       = last_y_ff;
      rsp_event_in    = rsp_event_ff;
      rsp_touched_in  = rsp_touched_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;

      if (req_accept) begin
         samp_a_in  = req_ch.sample_a;
         samp_b_in  = req_ch.sample_b;
         pressed_in = any_low;
      end

      unique case (state_ff)
         ST_SCALE: begin
            prod_x_in = SCALE_W'(samp_a_ff) * SCALE_W'(cfg_ff.x_span);
            prod_y_in = SCALE_W'(samp_b_ff) * SCALE_W'(cfg_ff.y_span);
         end
         ST_DIV: begin
            div_x_in = DIV100_W'(prod_x_ff) * DIV100_W'(DIV100_RECIP);
            div_y_in = DIV100_W'(prod_y_ff) * DIV100_W'(DIV100_RECIP);
         end
         ST_MUL: begin
            mul_x_in = CAL_PROD_W'($signed({1'b0, raw_x})) * CAL_PROD_W'(cfg_ff.x_slope);
            mul_y_in = CAL_PROD_W'($signed({1'b0, raw_y})) * CAL_PROD_W'(cfg_ff.y_slope);
         end
         ST_SAT: begin
            cal_x_in = cal_sat(mul_x_ff, cfg_ff.x_offset);
            cal_y_in = cal_sat(mul_y_ff, cfg_ff.y_offset);
         end
         ST_ACC: begin
            sum_x_in = sum_x_ff + SUM_W'(cal_x_ff) - SUM_W'(old_entry.x);
            sum_y_in = sum_y_ff + SUM_W'(cal_y_ff) - SUM_W'(old_entry.y);
            slot_in  = (slot_ff == ADDR_W'(AVG_DEPTH - 1)) ? '0 : slot_ff + ADDR_W'(1);
         end
         ST_AVG: begin
            avgp_x_in = AVGP_W'(mag_x) * AVGP_W'(AVG_RECIP);
            avgp_y_in = AVGP_W'(mag_y) * AVGP_W'(AVG_RECIP);
            neg_x_in  = sum_x_ff[SUM_W-1];
            neg_y_in  = sum_y_ff[SUM_W-1];
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in    = 1'b1;
               rsp_event_in    = ev;
               rsp_touched_in  = pressed_ff;
               rsp_x_in        = px;
               rsp_y_in        = py;
               last_pressed_in = pressed_ff;
               last_x_in       = px;
               last_y_in       = py;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cfg_ff          <= CFG_RESET;
         slot_ff         <= '0;
         sum_x_ff        <= '0;
         sum_y_ff        <= '0;
         last_pressed_ff <= 1'b0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cfg_ff          <= cfg_in;
         slot_ff         <= slot_in;
         sum_x_ff        <= sum_x_in;
         sum_y_ff        <= sum_y_in;
         last_pressed_ff <= last_pressed_in;
         last_x_ff       <= last_x_in;
         last_y_ff       <= last_y_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_a_ff      <= samp_a_in;
      samp_b_ff      <= samp_b_in;
      pressed_ff     <= pressed_in;
      prod_x_ff      <= prod_x_in;
      prod_y_ff      <= prod_y_in;
      div_x_ff       <= div_x_in;
      div_y_ff       <= div_y_in;
      mul_x_ff       <= mul_x_in;
      mul_y_ff       <= mul_y_in;
      cal_x_ff       <= cal_x_in;
      cal_y_ff       <= cal_y_in;
      avgp_x_ff      <= avgp_x_in;
      avgp_y_ff      <= avgp_y_in;
      neg_x_ff       <= neg_x_in;
      neg_y_ff       <= neg_y_in;
      rsp_event_ff   <= rsp_event_in;
      rsp_touched_ff <= rsp_touched_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.touch_event = rsp_event_ff;
   assign rsp_ch.touched     = rsp_touched_ff;
   assign rsp_ch.pos_x       = rsp_x_ff;
   assign rsp_ch.pos_y       = rsp_y_ff;

endmodule
